// File: sv/mphl_pkg.sv
package mphl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_KEY_LEN_DEF = 64;

    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

    // word kinds on the input stream
    localparam logic [1:0] KIND_DISP  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_KEY   = 2'd2;

    // lookup error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_SLOT     = 2'd2;

    localparam int SIZE_W  = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic       take;         // input port open
        logic       err_load;
        logic [1:0] err_code;
        logic       div_load;
        logic       div_src_rh;   // divide rehash result instead of running hash
        logic       div_step;
        logic       disp_rd;
        logic       fin_rd;
        logic       fin_direct;   // final table address from direct slot
        logic       rh_init;
        logic       rh_rd;
        logic       rh_step;
        logic       out_load;
    } mphl_cmd_t;

    typedef struct packed {
        logic key_last;   // last key byte accepted this cycle
        logic too_long;
        logic div_done;
        logic disp_neg;
        logic slot_oor;
        logic rh_done;
        logic out_free;
    } mphl_status_t;

endpackage

// File: sv/minimal_perfect_hash_lookup_top.sv
// Two-level minimal perfect hash lookup. Input words of kind 0 and 1 load the
// displacement and final index tables; kind 2 words carry key bytes, hashed
// one per cycle as they arrive while the input is open, and kept in a key
// buffer. On the byte marked tlast the block takes the hash modulo table_size
// (0 taken as 1, capped at TABLE_DEPTH) in a one-bit-per-cycle divider, reads
// the displacement, and either reads the final table directly or rehashes the
// buffered key, reading and then mixing each byte in turn, and divides again.
// The input stays closed from the last byte of a key until its result word is
// loaded into the output register, and that load waits while an earlier result
// word still holds the register. A result word sits in an output register, and
// table writes and key bytes are still taken while it waits. table_size is
// written through cfg_we/cfg_wdata; the user must write it only while the block
// is idle, which the block itself does not enforce.
module minimal_perfect_hash_lookup_top #(
    parameter int TABLE_DEPTH = mphl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_LEN = mphl_pkg::MAX_KEY_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,       // table_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,    // table_index[9:0], entry_value[41:10], key_byte[49:42]
    input  logic [1:0]  s_axis_tuser,    // kind[1:0]
    input  logic        s_axis_tlast,    // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // file_index[9:0]
    output logic [1:0]  m_axis_tuser     // lookup_error[1:0]
);
    import mphl_pkg::*;

    mphl_cmd_t          cmd;
    mphl_status_t       status;
    logic [INDEX_W-1:0] file_index;

    mphl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mphl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_index  (s_axis_tdata[9:0]),
        .in_value  (s_axis_tdata[41:10]),
        .in_byte   (s_axis_tdata[49:42]),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_index (file_index),
        .out_error (m_axis_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    assign s_axis_tready = cmd.take;
    assign m_axis_tdata  = {6'b0, file_index};

endmodule

// File: sv/mphl_ctrl.sv
module mphl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mphl_pkg::mphl_status_t status,
    output mphl_pkg::mphl_cmd_t    cmd
);
    import mphl_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_CHECK   = 10'b00_0000_0010,
        ST_DIV_D   = 10'b00_0000_0100,
        ST_DISP_RD = 10'b00_0000_1000,
        ST_DISP    = 10'b00_0001_0000,
        ST_RH_RD   = 10'b00_0010_0000,
        ST_RH_STEP = 10'b00_0100_0000,
        ST_DIV_F   = 10'b00_1000_0000,
        ST_FIN_RD  = 10'b01_0000_0000,
        ST_FIN     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.key_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.err_load = 1'b1;
                if (status.too_long)
                begin
                    cmd.err_code = ERR_TOO_LONG;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.err_code = ERR_NONE;
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV_D;
                end
            end
            ST_DIV_D:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DISP_RD;
                end
            end
            ST_DISP_RD:
            begin
                cmd.disp_rd = 1'b1;
                state_next  = ST_DISP;
            end
            ST_DISP:
            begin
                if (status.disp_neg)
                begin
                    if (status.slot_oor)
                    begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = ERR_SLOT;
                    end
                    else
                    begin
                        cmd.fin_rd     = 1'b1;
                        cmd.fin_direct = 1'b1;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rh_init = 1'b1;
                    state_next  = ST_RH_RD;
                end
            end
            ST_RH_RD:
            begin
                if (status.rh_done)
                begin
                    cmd.div_load   = 1'b1;
                    cmd.div_src_rh = 1'b1;
                    state_next     = ST_DIV_F;
                end
                else
                begin
                    cmd.rh_rd  = 1'b1;
                    state_next = ST_RH_STEP;
                end
            end
            ST_RH_STEP:
            begin
                cmd.rh_step = 1'b1;
                state_next  = ST_RH_RD;
            end
            ST_DIV_F:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_FIN_RD:
            begin
                cmd.fin_rd = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/mphl_datapath.sv
module mphl_datapath #(
    parameter int TABLE_DEPTH = mphl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_LEN = mphl_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mphl_pkg::SIZE_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    input  logic [1:0]                          in_kind,
    input  logic [mphl_pkg::INDEX_W-1:0]        in_index,
    input  logic [mphl_pkg::VALUE_W-1:0]        in_value,
    input  logic [7:0]                          in_byte,
    input  logic                                in_last,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mphl_pkg::INDEX_W-1:0]        out_index,
    output logic [1:0]                          out_error,
    input  mphl_pkg::mphl_cmd_t                 cmd,
    output mphl_pkg::mphl_status_t              status
);
    import mphl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int LW = $clog2(MAX_KEY_LEN + 2);

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] ext;
        ext = {{24{b[7]}}, b};
        return (h * FNV_PRIME) ^ ext;
    endfunction

    logic [VALUE_W-1:0] disp_mem [TABLE_DEPTH];
    logic [INDEX_W-1:0] fin_mem  [TABLE_DEPTH];
    logic [7:0]         key_mem  [MAX_KEY_LEN];

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    eff_size;
    logic [LW-1:0]        key_len_reg;
    logic [31:0]          run_hash_reg;
    logic [31:0]          rh_hash_reg;
    logic [LW-1:0]        rh_idx_reg;
    logic [31:0]          dvd_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [VALUE_W-1:0]   disp_rdata_reg;
    logic [INDEX_W-1:0]   fin_rdata_reg;
    logic [7:0]           key_rdata_reg;
    logic [1:0]           err_reg;
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [1:0]           out_error_reg;

    logic                 accept;
    logic                 take_key;
    logic                 tbl_ok;
    logic [31:0]          idx_ext;
    logic [31:0]          fnv_src;
    logic [7:0]           fnv_byte;
    logic [31:0]          fnv_out;
    logic [SIZE_W:0]      rem_shift;
    logic [31:0]          slot;
    logic [AW-1:0]        fin_addr;

    assign accept   = cmd.take & in_valid;
    assign take_key = accept && (in_kind == KIND_KEY);
    assign idx_ext  = 32'(in_index);
    assign tbl_ok   = idx_ext < 32'(TABLE_DEPTH);
    assign slot     = ~disp_rdata_reg;
    assign fin_addr = cmd.fin_direct ? slot[AW-1:0] : rem_reg[AW-1:0];

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(size_reg) > 32'(TABLE_DEPTH))
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    // one multiplier serves both the streaming hash and the rehash
    assign fnv_src  = cmd.rh_step ? rh_hash_reg : run_hash_reg;
    assign fnv_byte = cmd.rh_step ? key_rdata_reg : in_byte;
    assign fnv_out  = fnv_step(fnv_src, fnv_byte);

    assign rem_shift = {rem_reg, dvd_reg[31]};

    always_ff @(posedge clk)
    begin
        if (accept && (in_kind == KIND_DISP) && tbl_ok)
        begin
            disp_mem[idx_ext[AW-1:0]] <= in_value;
        end
        if (cmd.disp_rd)
        begin
            disp_rdata_reg <= disp_mem[rem_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_kind == KIND_FINAL) && tbl_ok)
        begin
            fin_mem[idx_ext[AW-1:0]] <= in_value[INDEX_W-1:0];
        end
        if (cmd.fin_rd)
        begin
            fin_rdata_reg <= fin_mem[fin_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_key && (key_len_reg < LW'(MAX_KEY_LEN)))
        begin
            key_mem[key_len_reg[KW-1:0]] <= in_byte;
        end
        if (cmd.rh_rd)
        begin
            key_rdata_reg <= key_mem[rh_idx_reg[KW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_W'(1);
            key_len_reg   <= '0;
            run_hash_reg  <= FNV_PRIME;
            rh_hash_reg   <= FNV_PRIME;
            rh_idx_reg    <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_error_reg <= ERR_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (take_key)
            begin
                if (key_len_reg <= LW'(MAX_KEY_LEN))
                begin
                    key_len_reg <= key_len_reg + LW'(1);
                end
                run_hash_reg <= fnv_out;
            end
            if (cmd.rh_init)
            begin
                rh_hash_reg <= (disp_rdata_reg == '0) ? FNV_PRIME : disp_rdata_reg;
                rh_idx_reg  <= '0;
            end
            if (cmd.rh_step)
            begin
                rh_hash_reg <= fnv_out;
                rh_idx_reg  <= rh_idx_reg + LW'(1);
            end
            // restoring remainder, one dividend bit per cycle
            if (cmd.div_load)
            begin
                dvd_reg     <= cmd.div_src_rh ? rh_hash_reg : run_hash_reg;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                if (rem_shift >= {1'b0, eff_size})
                begin
                    rem_reg <= SIZE_W'(rem_shift - {1'b0, eff_size});
                end
                else
                begin
                    rem_reg <= rem_shift[SIZE_W-1:0];
                end
                dvd_reg     <= {dvd_reg[30:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.err_load)
            begin
                err_reg <= cmd.err_code;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_index_reg <= (err_reg == ERR_NONE) ? fin_rdata_reg : '0;
                out_error_reg <= err_reg;
                key_len_reg   <= '0;
                run_hash_reg  <= FNV_PRIME;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.key_last = take_key & in_last;
    assign status.too_long = key_len_reg > LW'(MAX_KEY_LEN);
    assign status.div_done = div_cnt_reg == {DIV_CNT_W{1'b1}};
    assign status.disp_neg = disp_rdata_reg[VALUE_W-1];
    assign status.slot_oor = slot >= 32'(eff_size);
    assign status.rh_done  = rh_idx_reg == key_len_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_error = out_error_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= LW'(MAX_KEY_LEN + 1))
        else $error("key length past saturation");

    a_rh_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rh_rd || cmd.rh_step) |-> (rh_idx_reg < key_len_reg))
        else $error("rehash index past key length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a pending word");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.disp_rd || (cmd.fin_rd && !cmd.fin_direct)) |-> (rem_reg < eff_size))
        else $error("remainder not below table size");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output valid without a loaded result");

endmodule

// File: test/tb_minimal_perfect_hash_lookup_top.sv
module tb_minimal_perfect_hash_lookup_top;
    import mphl_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int KEY_MAX    = 64;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = 300;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  tidx;
        logic [31:0] val;
        logic [7:0]  kbyte;
        logic        last;
    } word_t;

    typedef struct {
        logic [9:0] fidx;
        logic [1:0] err;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    word_t   pend_q[$];
    lookup_t want_q[$];
    word_t   cur;
    int      send_idle;
    int      recv_stall;
    int      errors;
    int      stall_cnt;

    // generator bookkeeping: which table entries have been loaded
    bit      disp_loaded[DEPTH];
    bit      fin_loaded[DEPTH];

    // predictor state
    logic [31:0] disp_mem[DEPTH];
    logic [9:0]  fin_mem[DEPTH];
    logic [7:0]  kbuf[KEY_MAX];
    int          klen;
    logic [31:0] rhash;
    logic [10:0] size_reg;

    minimal_perfect_hash_lookup_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
        return (h * FNV_PRIME) ^ {{24{b[7]}}, b};
    endfunction

    function automatic int eff_size(logic [10:0] s);
        if (s == 0)
            return 1;
        if (s > DEPTH)
            return DEPTH;
        return s;
    endfunction

    task automatic hash_lookup_predict(word_t w);
        lookup_t     r;
        int          sz;
        logic [31:0] d;
        logic [31:0] slot;
        logic [31:0] h;
        if (w.kind == KIND_DISP)
            disp_mem[w.tidx] = w.val;
        else if (w.kind == KIND_FINAL)
            fin_mem[w.tidx] = w.val[9:0];
        else if (w.kind == KIND_KEY)
        begin
            if (klen < KEY_MAX)
                kbuf[klen] = w.kbyte;
            if (klen <= KEY_MAX)
                klen++;
            rhash = fnv_mix(rhash, w.kbyte);
            if (w.last)
            begin
                sz = eff_size(size_reg);
                r.fidx = '0;
                r.err = ERR_NONE;
                if (klen > KEY_MAX)
                    r.err = ERR_TOO_LONG;
                else
                begin
                    d = disp_mem[rhash % sz];
                    if (d[31])
                    begin
                        slot = ~d;
                        if (slot >= sz)
                            r.err = ERR_SLOT;
                        else
                            r.fidx = fin_mem[slot];
                    end
                    else
                    begin
                        h = (d == 0) ? FNV_PRIME : d;
                        for (int i = 0; i < klen; i++)
                            h = fnv_mix(h, kbuf[i]);
                        r.fidx = fin_mem[h % sz];
                    end
                end
                want_q.insert(want_q.size(), r);
                klen = 0;
                rhash = FNV_PRIME;
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                hash_lookup_predict(cur);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cur = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, cur.kbyte, cur.val, cur.tidx};
                    s_axis_tuser  <= cur.kind;
                    s_axis_tlast  <= cur.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        lookup_t w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (want_q.size() == 0)
                begin
                    $error("unexpected result word fidx=%0d err=%0d",
                           m_axis_tdata[9:0], m_axis_tuser);
                    errors++;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (m_axis_tdata[9:0] !== w.fidx)
                    begin
                        $error("file_index expected %0d actual %0d", w.fidx, m_axis_tdata[9:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== w.err)
                    begin
                        $error("lookup_error expected %0d actual %0d", w.err, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cnt <= 0;
            else if (pend_q.size() != 0 || s_axis_tvalid || want_q.size() != 0)
            begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt >= STALL_MAX)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    function automatic logic [31:0] pick_disp(int sz);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(-$urandom_range(1, sz));
            2: return 32'(-(sz + $urandom_range(1, 8)));
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic enqueue_word(logic [1:0] kind, logic [9:0] tidx, logic [31:0] val,
                                logic [7:0] kbyte, logic last);
        word_t w;
        w.kind = kind;
        w.tidx = tidx;
        w.val = val;
        w.kbyte = kbyte;
        w.last = last;
        pend_q.insert(pend_q.size(), w);
        if (kind == KIND_DISP)
            disp_loaded[tidx] = 1'b1;
        if (kind == KIND_FINAL)
            fin_loaded[tidx] = 1'b1;
    endtask

    // key bytes carry random unused fields so the index and value bits of tdata toggle
    task automatic push_key(int len);
        for (int i = 0; i < len; i++)
            enqueue_word(KIND_KEY, 10'($urandom), $urandom, 8'($urandom), i == len - 1);
    endtask

    // load every entry a lookup at this size can read
    task automatic fill_tables(int sz);
        for (int i = 0; i < sz; i++)
        begin
            if (!disp_loaded[i])
                enqueue_word(KIND_DISP, 10'(i), pick_disp(sz), 8'($urandom), 1'($urandom));
            if (!fin_loaded[i])
                enqueue_word(KIND_FINAL, 10'(i), $urandom, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain;
        while (pend_q.size() != 0 || s_axis_tvalid || want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_size(logic [10:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        size_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [10:0] sizes[8];
        int          sz;
        int          r;
        int          len;
        sizes = '{11'd4, 11'd1, 11'd64, 11'd0, 11'd37, 11'd5, 11'd2, 11'd13};
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        klen = 0;
        rhash = FNV_PRIME;
        size_reg = 11'd1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 52; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 52; end
                default: begin send_idle = 34; recv_stall = 34; end
            endcase
            set_size(sizes[p]);
            sz = eff_size(sizes[p]);
            if (p == 0)
            begin
                // extremes of the displacement: most negative, -1, zero seed, max positive
                enqueue_word(KIND_DISP, 0, 32'h8000_0000, 8'h00, 1'b0);
                enqueue_word(KIND_DISP, 1, ALL_ONES, 8'hff, 1'b1);
                enqueue_word(KIND_DISP, 2, 32'h0, 8'h00, 1'b0);
                enqueue_word(KIND_DISP, 3, 32'h7fff_ffff, 8'hff, 1'b1);
                enqueue_word(KIND_FINAL, 0, ALL_ONES, 8'h00, 1'b0);
                enqueue_word(KIND_FINAL, 1, 32'h0, 8'h00, 1'b0);
                enqueue_word(KIND_FINAL, 2, 32'h1234_5a5a, 8'h00, 1'b0);
                enqueue_word(KIND_FINAL, 3, 32'h8000_03ff, 8'h00, 1'b0);
                // writes above the size are stored, an unused kind is dropped
                enqueue_word(KIND_FINAL, 10'd1023, 32'h0000_0155, 8'h00, 1'b0);
                enqueue_word(KIND_UNUSED, 10'd1023, ALL_ONES, 8'hff, 1'b1);
                enqueue_word(KIND_KEY, 0, 0, 8'h00, 1'b1);
                enqueue_word(KIND_KEY, 0, 0, 8'h80, 1'b0);
                enqueue_word(KIND_KEY, 0, 0, 8'h7f, 1'b0);
                enqueue_word(KIND_KEY, 0, 0, 8'hff, 1'b1);
                push_key(KEY_MAX);
                push_key(KEY_MAX + 3);
                push_key(1);
            end
            fill_tables(sz);
            for (int n = 0; n < 10; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(1, 6);
                    push_key(len);
                end
                else if (r < 82)
                    enqueue_word(KIND_DISP,
                                 10'((r < 72) ? $urandom_range(0, sz - 1) : $urandom),
                                 pick_disp(sz), 8'($urandom), 1'($urandom));
                else if (r < 96)
                    enqueue_word(KIND_FINAL, 10'($urandom), $urandom, 8'($urandom),
                                 1'($urandom));
                else
                    enqueue_word(KIND_UNUSED, 10'($urandom), $urandom, 8'($urandom),
                                 1'($urandom));
            end
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: filelist.f
sv/mphl_pkg.sv
sv/mphl_ctrl.sv
sv/mphl_datapath.sv
sv/minimal_perfect_hash_lookup_top.sv
test/tb_minimal_perfect_hash_lookup_top.sv
